FILE: rtl/bia_pkg.sv
// Shared types and constants for the bitmap ID allocator.
package bia_pkg;

  localparam int ID_W  = 8;
  localparam int CNT_W = 9;
  localparam int CFG_W = 9;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_CLAIM   = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

endpackage

FILE: rtl/bia_bitmap_ram.sv
// Bitmap word memory: one write port, one registered read port.
module bia_bitmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

FILE: rtl/bia_ctrl.sv
// Command sequencer: clear pass, word scan for allocate, bit test and update for named IDs.
module bia_ctrl #(
  parameter int WORD_BITS = 8,
  parameter int NUM_WORDS = 32,
  parameter int AW        = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bia_pkg::CFG_W-1:0]   limit_i,
  input  logic                        start_i,
  input  logic [1:0]                  cmd_i,
  input  logic [bia_pkg::ID_W-1:0]    id_i,
  output logic                        busy_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [WORD_BITS-1:0]        mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [WORD_BITS-1:0]        mem_rdata_i,
  output logic                        out_valid_o,
  output logic [1:0]                  out_status_o,
  output logic [bia_pkg::ID_W-1:0]    out_result_id_o,
  output logic                        out_in_use_o,
  output logic [bia_pkg::CNT_W-1:0]   out_count_o
);

  localparam int OW      = $clog2(WORD_BITS);
  localparam int BASE_W  = bia_pkg::CFG_W + 1;
  localparam int DIV_SH  = 24;
  localparam int PROD_W  = bia_pkg::ID_W + DIV_SH + 1;
  localparam int RECIP   = (2**DIV_SH + WORD_BITS - 1) / WORD_BITS;
  localparam int ID_W    = bia_pkg::ID_W;
  localparam int CNT_W   = bia_pkg::CNT_W;

  bia_pkg::state_t  state_r, state_nxt;
  bia_pkg::cmd_t    cmd_r, cmd_in;
  logic [ID_W-1:0]  id_r;
  logic [OW-1:0]    off_r;
  logic             oor_r;
  logic [AW-1:0]    word_r;
  logic [BASE_W-1:0] base_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             out_valid_r;
  bia_pkg::status_t out_status_r, res_status;
  logic [ID_W-1:0]  out_id_r, res_id;
  logic             out_in_use_r, res_in_use;

  // Word index and bit offset of a named ID, by reciprocal multiply.
  logic [PROD_W-1:0] div_prod;
  logic [ID_W-1:0]   id_q;
  logic [OW-1:0]     id_rem;
  logic              in_oor;
  logic [AW-1:0]     start_addr;
  logic [AW-1:0]     next_word;

  logic              free_found;
  logic [OW-1:0]     free_j;
  logic [BASE_W-1:0] cand;
  logic [BASE_W-1:0] limit_ext;
  logic              room;
  logic              alloc_hit;
  logic              alloc_more;
  logic              bit_now;
  logic              finish;

  assign cmd_in   = bia_pkg::cmd_t'(cmd_i);
  assign div_prod = PROD_W'(id_i) * PROD_W'(RECIP);
  assign id_q     = div_prod[DIV_SH +: ID_W];
  assign id_rem   = OW'(id_i - ID_W'(int'(id_q) * WORD_BITS));
  assign in_oor   = {1'b0, id_i} >= limit_i;
  assign start_addr = (cmd_in == bia_pkg::CMD_ALLOC || in_oor) ? '0 : AW'(id_q);
  assign next_word  = (word_r == AW'(NUM_WORDS - 1)) ? '0 : word_r + 1'b1;

  // Lowest clear bit of the word under test.
  always_comb begin
    free_found = 1'b0;
    free_j     = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!mem_rdata_i[j]) begin
        free_found = 1'b1;
        free_j     = OW'(j);
      end
    end
  end

  assign cand       = base_r + BASE_W'(free_j);
  assign limit_ext  = BASE_W'(limit_i);
  assign room       = count_r < limit_i;
  assign alloc_hit  = room && free_found && (cand < limit_ext);
  assign alloc_more = room && !alloc_hit && ((base_r + BASE_W'(WORD_BITS)) < limit_ext);
  assign bit_now    = mem_rdata_i[off_r];
  assign finish     = (state_r == bia_pkg::S_LOOK) &&
                      !(cmd_r == bia_pkg::CMD_ALLOC && alloc_more);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bia_pkg::S_CLEAR: begin
        if (word_r == AW'(NUM_WORDS - 1)) state_nxt = bia_pkg::S_IDLE;
      end
      bia_pkg::S_IDLE: begin
        if (start_i) state_nxt = bia_pkg::S_LOOK;
      end
      bia_pkg::S_LOOK: begin
        if (finish) state_nxt = bia_pkg::S_IDLE;
      end
      default: state_nxt = bia_pkg::S_IDLE;
    endcase
  end

  // Outputs, memory access and result.
  always_comb begin
    busy_o      = (state_r != bia_pkg::S_IDLE);
    mem_we_o    = 1'b0;
    mem_waddr_o = word_r;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = start_addr;
    count_nxt   = count_r;
    res_status  = bia_pkg::ST_DONE;
    res_id      = id_r;
    res_in_use  = 1'b0;
    unique case (state_r)
      bia_pkg::S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = '0;
      end
      bia_pkg::S_IDLE: begin
        mem_raddr_o = start_addr;
      end
      bia_pkg::S_LOOK: begin
        mem_raddr_o = next_word;
        unique case (cmd_r)
          bia_pkg::CMD_ALLOC: begin
            res_id     = '0;
            res_status = bia_pkg::ST_REFUSED;
            if (alloc_hit) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = mem_rdata_i | (WORD_BITS'(1) << free_j);
              res_id      = ID_W'(cand);
              res_status  = bia_pkg::ST_DONE;
              count_nxt   = count_r + 1'b1;
            end
          end
          bia_pkg::CMD_CLAIM: begin
            if (oor_r) begin
              res_status = bia_pkg::ST_RANGE;
            end else if (bit_now) begin
              res_in_use = 1'b1;
              res_status = bia_pkg::ST_REFUSED;
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = mem_rdata_i | (WORD_BITS'(1) << off_r);
              count_nxt   = count_r + 1'b1;
            end
          end
          bia_pkg::CMD_QUERY: begin
            if (oor_r) begin
              res_status = bia_pkg::ST_RANGE;
            end else begin
              res_in_use = bit_now;
            end
          end
          bia_pkg::CMD_RELEASE: begin
            if (oor_r) begin
              res_status = bia_pkg::ST_RANGE;
            end else if (!bit_now) begin
              res_status = bia_pkg::ST_REFUSED;
            end else begin
              res_in_use  = 1'b1;
              mem_we_o    = 1'b1;
              mem_wdata_o = mem_rdata_i & ~(WORD_BITS'(1) << off_r);
              // hold at zero rather than wrap
              count_nxt   = (count_r == '0) ? '0 : count_r - 1'b1;
            end
          end
          default: res_status = bia_pkg::ST_DONE;
        endcase
      end
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bia_pkg::S_CLEAR;
      word_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish;
      count_r     <= count_nxt;
      unique case (state_r)
        bia_pkg::S_CLEAR: word_r <= next_word;
        bia_pkg::S_IDLE: begin
          if (start_i) word_r <= start_addr;
        end
        bia_pkg::S_LOOK: begin
          if (!finish) word_r <= next_word;
        end
        default: word_r <= '0;
      endcase
    end
  end

  // Command word and result payload.
  always_ff @(posedge clk) begin
    if (state_r == bia_pkg::S_IDLE && start_i) begin
      cmd_r  <= cmd_in;
      id_r   <= id_i;
      off_r  <= id_rem;
      oor_r  <= in_oor;
      base_r <= '0;
    end else if (state_r == bia_pkg::S_LOOK && !finish) begin
      // advance to the next bitmap word
      base_r <= base_r + BASE_W'(WORD_BITS);
    end
    if (finish) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_in_use_r <= res_in_use;
    end
  end

  assign out_valid_o     = out_valid_r;
  assign out_status_o    = out_status_r;
  assign out_result_id_o = out_id_r;
  assign out_in_use_o    = out_in_use_r;
  assign out_count_o     = count_r;

  a_strobe_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == bia_pkg::S_LOOK)
    else $error("result strobe without a finished lookup");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we_o |-> state_r != bia_pkg::S_IDLE)
    else $error("bitmap written while idle");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) ||
                      count_r == $past(count_r) + 1'b1 ||
                      count_r == $past(count_r) - 1'b1))
    else $error("count moved by more than one");

  a_range_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == bia_pkg::ST_RANGE) |-> $stable(count_r))
    else $error("out-of-range command changed the count");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bia_pkg::S_CLEAR) |-> (busy_o && !out_valid_r))
    else $error("ready or result during clear pass");

endmodule

FILE: rtl/bitmap_id_allocator.sv
// Bitmap ID allocator top level: limit register, sequencer and bitmap memory.
// Named commands (claim, query, release): one word is read and tested.
// Allocate: scans from word 0, one bitmap word per cycle through the
//   single memory read port, up to NUM_WORDS words.
// A new command may start in the cycle that out_valid is high.
// Reset: count zero, limit 256; then a clear pass writes every bitmap word to zero,
//   with busy high. Results are strobed and cannot be stalled.
module bitmap_id_allocator #(
  parameter int MAX_IDS   = 256,
  parameter int WORD_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_command,
  input  logic [bia_pkg::ID_W-1:0]  in_id_value,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [bia_pkg::ID_W-1:0]  out_result_id,
  output logic                      out_in_use,
  output logic [bia_pkg::CNT_W-1:0] out_allocated_count,
  input  logic                      cfg_we,
  input  logic [bia_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int NUM_WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CFG_W     = bia_pkg::CFG_W;

  logic [CFG_W-1:0]     range_r;
  logic [CFG_W-1:0]     limit;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= bia_pkg::CFG_RESET;
    end else if (cfg_we) begin
      range_r <= cfg_wdata;
    end
  end

  // Clamp the programmed range to the bitmap size.
  assign limit = (int'(range_r) > MAX_IDS) ? CFG_W'(MAX_IDS) : range_r;

  bia_ctrl #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .limit_i         (limit),
    .start_i         (start),
    .cmd_i           (in_command),
    .id_i            (in_id_value),
    .busy_o          (busy),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .out_valid_o     (out_valid),
    .out_status_o    (out_status),
    .out_result_id_o (out_result_id),
    .out_in_use_o    (out_in_use),
    .out_count_o     (out_allocated_count)
  );

  bia_bitmap_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
